FILE: src/dbpc_pkg.sv
package dbpc_pkg;

  localparam int unsigned STEPS_W     = 8;
  localparam int unsigned LONG_MS_W   = 16;
  localparam int unsigned NOW_W       = 32;
  localparam int unsigned CFG_ADDR_W  = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [STEPS_W-1:0]   RST_DEBOUNCE_STEPS = 8'd5;
  localparam logic [LONG_MS_W-1:0] RST_LONG_PRESS_MS  = 16'd1000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEBOUNCE_STEPS = 1'b0,
    REG_LONG_PRESS_MS  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_PRESSED   = 3'd1,
    EV_LONG      = 3'd2,
    EV_REL_SHORT = 3'd3,
    EV_REL_LONG  = 3'd4
  } event_t;

endpackage

FILE: src/button_debounce_press_classifier.sv
// channel | direction | tdata fields (lsb first)        | tuser | tlast
// in_     | slave     | line_level[0], now_ms[32:1]      | -     | -
// out_    | master    | event_code[2:0]                  | -     | -
// cfg_    | write     | cfg_addr selects register, cfg_wdata value
//
// one request per cycle unless out_ stalls; an input register, then the
// debounce and classify logic into the output register
// synchronous active-low reset: steps 5, long press 1000 ms, released
// a stall on out_tready holds the output register; in_tready drops only
// when both registers are full
module button_debounce_press_classifier #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dbpc_pkg::IN_TDATA_W-1:0]     in_tdata,   // line_level, now_ms
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dbpc_pkg::OUT_TDATA_W-1:0]    out_tdata,  // event_code
  input  logic                                cfg_we,
  input  logic [dbpc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dbpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dbpc_pkg::*;

  logic             s1_valid_r;
  logic             s1_line_r;
  logic [NOW_W-1:0] s1_now_r;
  logic             out_valid_r;
  event_t           out_ev_r;
  logic             advance;
  logic             step_en;
  event_t           ev;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign step_en   = s1_valid_r && advance;

  dbpc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .step_en    (step_en),
    .line_level (s1_line_r),
    .now_ms     (s1_now_r),
    .event_code (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_line_r <= in_tdata[0];
      s1_now_r  <= in_tdata[NOW_W:1];
    end
    if (step_en) begin
      out_ev_r <= ev;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_ev_r);

endmodule

FILE: src/dbpc_core.sv
module dbpc_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dbpc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dbpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                step_en,
  input  logic                                line_level,
  input  logic [dbpc_pkg::NOW_W-1:0]          now_ms,
  output dbpc_pkg::event_t                    event_code
);
  import dbpc_pkg::*;

  logic [STEPS_W-1:0]   debounce_steps_r;
  logic [LONG_MS_W-1:0] long_press_ms_r;
  logic [STEPS_W-1:0]   countdown_r;
  logic [STEPS_W-1:0]   countdown_nxt;
  logic                 last_debounced_r;
  logic                 last_debounced_nxt;
  logic [TIME_BITS-1:0] start_time_r;
  logic [TIME_BITS-1:0] start_time_nxt;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic                 cur;
  event_t               ev;

  assign now_t   = TIME_BITS'(now_ms);
  assign elapsed = now_t - start_time_r;

  always_comb begin
    countdown_nxt      = countdown_r;
    cur                = 1'b0;
    last_debounced_nxt = last_debounced_r;
    start_time_nxt     = start_time_r;
    ev                 = EV_NONE;

    // debounce: release takes effect at once
    if (line_level) begin
      countdown_nxt = debounce_steps_r - STEPS_W'(1);
    end else if (countdown_r == '0) begin
      cur = 1'b1;
    end else begin
      countdown_nxt = countdown_r - STEPS_W'(1);
    end

    if (cur == last_debounced_r) begin
      if (cur && (start_time_r != '0) &&
          (elapsed >= TIME_BITS'(long_press_ms_r))) begin
        start_time_nxt = '0;
        ev             = EV_LONG;
      end
    end else begin
      last_debounced_nxt = cur;
      if (cur) begin
        start_time_nxt = (now_t == '0) ? TIME_BITS'(1) : now_t;
        ev             = EV_PRESSED;
      end else begin
        ev = (start_time_r == '0) ? EV_REL_LONG : EV_REL_SHORT;
      end
    end
  end

  assign event_code = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_steps_r <= RST_DEBOUNCE_STEPS;
      long_press_ms_r  <= RST_LONG_PRESS_MS;
      countdown_r      <= RST_DEBOUNCE_STEPS - STEPS_W'(1);
      last_debounced_r <= 1'b0;
      start_time_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_DEBOUNCE_STEPS: debounce_steps_r <= cfg_wdata[STEPS_W-1:0];
          REG_LONG_PRESS_MS:  long_press_ms_r  <= cfg_wdata[LONG_MS_W-1:0];
          default: ;
        endcase
      end
      if (step_en) begin
        countdown_r      <= countdown_nxt;
        last_debounced_r <= last_debounced_nxt;
        start_time_r     <= start_time_nxt;
      end
    end
  end

endmodule
